>>> hdl/iiar_pkg.sv
// Shared types, widths and codes for the indexed insert/remove array unit.
// No dependencies; every other file in hdl/ imports this package.
package iiar_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]         element_count;
    logic [CNT_W-1:0]         reported_capacity;
  } rsp_t;

  // Shift controls broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

>>> hdl/indexed_insert_remove_array_unit.sv
// Top level of the indexed insert/remove array: command decode, count and
// capacity tracking, result register and the chain of iiar_cell storage cells.
// Depends on iiar_pkg and iiar_cell.
//
// Each transaction (append, insert, remove or read) is accepted on any cycle
// with start high; busy stays low, so a new transaction may follow every
// cycle. The result appears one cycle after acceptance with done high for that
// single cycle and must be captured then, since the receiver cannot stall it.
// All DEPTH cells shift in parallel in one clock, so insert and remove cost
// the same single cycle as append and read. element_count and
// reported_capacity are the low 7 bits of the internal values.
module indexed_insert_remove_array_unit #(
  parameter int DEPTH = iiar_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  iiar_pkg::req_t req,
  output logic           done,
  output iiar_pkg::rsp_t rsp
);
  import iiar_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic [CW-1:0]            capacity;
  logic [CW-1:0]            capacity_next;
  logic [CW:0]              cap_dbl;
  logic [PW-1:0]            pos_ext;
  logic [PW-1:0]            count_ext;
  logic [PW-1:0]            cell_pos;
  logic                     accept;
  logic                     is_full;
  logic                     ins_req;
  logic                     rem_req;
  logic                     rd_req;
  logic [STAT_W-1:0]        status_next;
  logic signed [WORD_W-1:0] rd_any;
  cell_ctrl_t               ctrl;
  logic signed [WORD_W-1:0] cell_data  [DEPTH];
  logic signed [WORD_W-1:0] cell_rd    [DEPTH];
  logic signed [WORD_W-1:0] left_bus   [DEPTH];
  logic signed [WORD_W-1:0] right_bus  [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Decode the command and check position and fullness
  always_comb begin
    pos_ext     = PW'(req.position);
    count_ext   = PW'(count);
    is_full     = (count == CW'(DEPTH));
    status_next = ST_OK;
    cell_pos    = pos_ext;
    ins_req     = 1'b0;
    rem_req     = 1'b0;
    rd_req      = 1'b0;
    case (req.cmd)
      CMD_APPEND: begin
        cell_pos = count_ext;
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ins_req = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (pos_ext > count_ext) begin
          status_next = ST_BADPOS;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          ins_req = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= count_ext) begin
          status_next = ST_BADPOS;
        end else begin
          rem_req = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_ext) begin
          status_next = ST_BADPOS;
        end else begin
          rd_req = 1'b1;
        end
      end
      default: begin
        status_next = ST_BADPOS;
      end
    endcase
    ctrl.ins = accept && ins_req;
    ctrl.rem = accept && rem_req;
  end

  // Grow capacity on a successful append or insert that finds it used up
  always_comb begin
    cap_dbl       = {capacity, 1'b0};
    capacity_next = capacity;
    count_next    = count;
    if (ins_req) begin
      count_next = count + 1'b1;
      if (count >= capacity) begin
        if (capacity == '0) begin
          capacity_next = CW'(1);
        end else if (cap_dbl > (CW + 1)'(DEPTH)) begin
          capacity_next = CW'(DEPTH);
        end else begin
          capacity_next = cap_dbl[CW-1:0];
        end
      end
    end else if (rem_req) begin
      count_next = count - 1'b1;
    end
  end

  // Merge the read bus; only the addressed cell drives nonzero
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  // Advance count and capacity, flag the result
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= '0;
      done     <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count    <= count_next;
        capacity <= capacity_next;
      end
    end
  end

  // Hold the result payload for its strobe cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status            <= status_next;
      rsp.read_value        <= rd_req ? rd_any : '0;
      rsp.element_count     <= CNT_W'(count_next);
      rsp.reported_capacity <= CNT_W'(capacity_next);
    end
  end

  // Chain of storage cells with neighbor links
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_bus[g] = '0;
    end else begin : g_mid
      assign left_bus[g] = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_bus[g] = cell_data[g];
    end else begin : g_body
      assign right_bus[g] = cell_data[g+1];
    end

    iiar_cell #(
      .PW  (PW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .pos        (cell_pos),
      .item_value (req.item_value),
      .left_data  (left_bus[g]),
      .right_data (right_bus[g]),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

endmodule

>>> hdl/iiar_cell.sv
// One storage cell of the array chain: holds one word and takes the word of
// its lower or upper neighbor on insert or remove. Depends on iiar_pkg.
module iiar_cell #(
  parameter int PW  = 7,
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  iiar_pkg::cell_ctrl_t               ctrl,
  input  logic [PW-1:0]                      pos,
  input  logic signed [iiar_pkg::WORD_W-1:0] item_value,
  input  logic signed [iiar_pkg::WORD_W-1:0] left_data,
  input  logic signed [iiar_pkg::WORD_W-1:0] right_data,
  output logic signed [iiar_pkg::WORD_W-1:0] data,
  output logic signed [iiar_pkg::WORD_W-1:0] rd_data
);
  import iiar_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(IDX);

  // Write the new word at the slot, move up above it, or move down on remove
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == pos) begin
        data <= item_value;
      end else if (MY_IDX > pos) begin
        data <= left_data;
      end
    end else if (ctrl.rem && (MY_IDX >= pos)) begin
      data <= right_data;
    end
  end

  // Drive the word onto the read bus only when addressed
  assign rd_data = (MY_IDX == pos) ? data : '0;

endmodule

>>> hdl/iiar_checker.sv
// Port-level checks for the indexed insert/remove array unit, bound to the
// top level. Depends on iiar_pkg and indexed_insert_remove_array_unit.
module iiar_checker #(
  parameter int DEPTH = iiar_pkg::DEPTH_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input iiar_pkg::rsp_t rsp
);
  import iiar_pkg::*;

  // Every accepted transaction yields exactly one result, in the following cycle
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy && !rst))
    else $error("result strobe does not match an accepted transaction");

  // A full status only when the array holds DEPTH elements
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_FULL)) |-> (rsp.element_count == CNT_W'(DEPTH)))
    else $error("full status with array not at depth");

  // Failed transactions return a zero read value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ST_OK)) |-> (rsp.read_value == '0))
    else $error("nonzero read value on a failed transaction");

  // Element count never exceeds the reported capacity; checked only when DEPTH is below 128
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (done && (DEPTH < 128)) |-> (rsp.element_count <= rsp.reported_capacity))
    else $error("element count above reported capacity");

endmodule

bind indexed_insert_remove_array_unit iiar_checker #(
  .DEPTH (DEPTH)
) u_iiar_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
